// ===== sv/jcc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jcc_pkg
// Types, constants and small functions of the Julian calendar converter.
// ----------------------------------------------------------------------------
package jcc_pkg;

    typedef enum logic {
        FUNC_TO_FIXED = 1'b0,
        FUNC_TO_DATE  = 1'b1
    } jcc_func_t;

    localparam int DAYS_PER_YEAR = 365;

    // year estimate: floor((4 * (rd - epoch) + YEAR_BIAS) / YEAR_DIV)
    localparam int YEAR_DIV     = 1461;
    localparam int YEAR_BIAS    = 1464;
    localparam int YEAR_SHIFT   = 39;
    localparam int YEAR_CYCLES  = 65536;
    localparam int YEAR_Q_W     = 17;
    localparam logic [28:0] YEAR_RECIP =
        29'(((64'd1 << YEAR_SHIFT) + 64'(YEAR_DIV) - 64'd1) / 64'(YEAR_DIV));
    localparam logic signed [28:0] YEAR_NUM_OFS =
        29'(YEAR_BIAS + YEAR_DIV * YEAR_CYCLES);
    localparam logic signed [17:0] YEAR_K_OFS = 18'(YEAR_CYCLES + 1);

    // month: floor((MONTH_MUL * days + MONTH_BIAS) / MONTH_DIV)
    localparam int MONTH_MUL   = 12;
    localparam int MONTH_BIAS  = 373;
    localparam int MONTH_DIV   = 367;
    localparam int MONTH_SHIFT = 22;
    localparam logic [13:0] MONTH_RECIP =
        14'(((64'd1 << MONTH_SHIFT) + 64'(MONTH_DIV) - 64'd1) / 64'(MONTH_DIV));

    localparam logic signed [17:0] YEAR_MAX = 18'sd32767;
    localparam logic signed [17:0] YEAR_MIN = -18'sd32768;

    typedef struct packed {
        jcc_func_t          func;
        logic               err;
        logic               leap;
        logic signed [24:0] rd;
        logic [27:0]        num;
        logic signed [15:0] k_date;
        logic signed [11:0] date_off;
        logic signed [15:0] year;
        logic [3:0]         month;
        logic [4:0]         day;
    } jcc_in_t;

    typedef struct packed {
        jcc_func_t          func;
        logic               err;
        logic               leap;
        logic signed [24:0] rd;
        logic signed [17:0] k;
        logic signed [11:0] date_off;
        logic signed [17:0] year;
        logic [3:0]         month;
        logic [4:0]         day;
    } jcc_yr_t;

    typedef struct packed {
        jcc_func_t          func;
        logic               err;
        logic               leap;
        logic signed [24:0] rd;
        logic signed [26:0] base;
        logic signed [17:0] year;
        logic [3:0]         month;
        logic [4:0]         day;
    } jcc_base_t;

    typedef struct packed {
        jcc_base_t          b;
        logic [8:0]         prior;
        logic [1:0]         corr;
        logic [3:0]         month_c;
    } jcc_cal_t;

    // floor((367 * m - 362) / 12): days before month m
    function automatic logic signed [10:0] month_lead(input logic [3:0] m);
        logic signed [10:0] r;
        case (m)
            4'd0:    r = -11'sd31;
            4'd1:    r = 11'sd0;
            4'd2:    r = 11'sd31;
            4'd3:    r = 11'sd61;
            4'd4:    r = 11'sd92;
            4'd5:    r = 11'sd122;
            4'd6:    r = 11'sd153;
            4'd7:    r = 11'sd183;
            4'd8:    r = 11'sd214;
            4'd9:    r = 11'sd245;
            4'd10:   r = 11'sd275;
            4'd11:   r = 11'sd306;
            4'd12:   r = 11'sd336;
            4'd13:   r = 11'sd367;
            4'd14:   r = 11'sd398;
            4'd15:   r = 11'sd428;
            default: r = 11'sd0;
        endcase
        return r;
    endfunction

    function automatic logic leap_of(input logic signed [17:0] y);
        logic r;
        if (y > 18'sd0) begin
            r = (y[1:0] == 2'd0);
        end else if (y < 18'sd0) begin
            r = (y[1:0] == 2'd3);
        end else begin
            r = 1'b0;
        end
        return r;
    endfunction

endpackage

// ===== sv/jcc_year_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jcc_year_div
// Two stages: year estimate by reciprocal multiply, then year number and leap.
// ----------------------------------------------------------------------------
module jcc_year_div (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  jcc_pkg::jcc_in_t in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output jcc_pkg::jcc_yr_t out_data
);

    logic                             va_reg;
    logic                             vb_reg;
    logic                             ce_a;
    logic                             ce_b;
    jcc_pkg::jcc_in_t                 a_reg;
    logic [jcc_pkg::YEAR_Q_W-1:0]     q_reg;
    logic [jcc_pkg::YEAR_Q_W-1:0]     q_next;
    logic [56:0]                      prod;
    jcc_pkg::jcc_yr_t                 b_reg;
    jcc_pkg::jcc_yr_t                 b_next;
    logic signed [17:0]               k_fix;
    logic signed [17:0]               y_fix;

    assign ce_b     = !vb_reg || out_ready;
    assign ce_a     = !va_reg || ce_b;
    assign in_ready = ce_a;

    always_comb begin
        prod   = 57'(in_data.num) * 57'(jcc_pkg::YEAR_RECIP);
        q_next = prod[jcc_pkg::YEAR_SHIFT +: jcc_pkg::YEAR_Q_W];
    end

    always_comb begin
        k_fix = $signed({1'b0, q_reg}) - jcc_pkg::YEAR_K_OFS;
        y_fix = (k_fix < 18'sd0) ? k_fix : k_fix + 18'sd1;
        b_next.func     = a_reg.func;
        b_next.err      = a_reg.err;
        b_next.rd       = a_reg.rd;
        b_next.date_off = a_reg.date_off;
        b_next.month    = a_reg.month;
        b_next.day      = a_reg.day;
        if (a_reg.func == jcc_pkg::FUNC_TO_DATE) begin
            b_next.k    = k_fix;
            b_next.year = y_fix;
            b_next.leap = jcc_pkg::leap_of(y_fix);
        end else begin
            b_next.k    = 18'(a_reg.k_date);
            b_next.year = 18'(a_reg.year);
            b_next.leap = a_reg.leap;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end else begin
            if (ce_a) begin
                va_reg <= in_valid;
            end
            if (ce_b) begin
                vb_reg <= va_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ce_a) begin
            a_reg <= in_data;
            q_reg <= q_next;
        end
        if (ce_b) begin
            b_reg <= b_next;
        end
    end

    assign out_valid = vb_reg;
    assign out_data  = b_reg;

endmodule

// ===== sv/jcc_year_base.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jcc_year_base
// Two stages: day count of January 1 of the year, or of the whole date.
// ----------------------------------------------------------------------------
module jcc_year_base (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic signed [10:0] epoch,
    input  logic               in_valid,
    output logic               in_ready,
    input  jcc_pkg::jcc_yr_t   in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output jcc_pkg::jcc_base_t out_data
);

    logic               va_reg;
    logic               vb_reg;
    logic               ce_a;
    logic               ce_b;
    jcc_pkg::jcc_yr_t   a_reg;
    logic signed [26:0] sum_reg;
    logic signed [26:0] sum_next;
    logic signed [26:0] k4_reg;
    logic signed [26:0] k4_next;
    jcc_pkg::jcc_base_t b_reg;
    jcc_pkg::jcc_base_t b_next;
    logic signed [26:0] off;

    assign ce_b     = !vb_reg || out_ready;
    assign ce_a     = !va_reg || ce_b;
    assign in_ready = ce_a;

    always_comb begin
        sum_next = 27'(in_data.k) * 27'(jcc_pkg::DAYS_PER_YEAR) + 27'(epoch);
        k4_next  = 27'(in_data.k >>> 2);
    end

    always_comb begin
        off = (a_reg.func == jcc_pkg::FUNC_TO_DATE) ? 27'sd0 : 27'(a_reg.date_off);
        b_next.func  = a_reg.func;
        b_next.err   = a_reg.err;
        b_next.leap  = a_reg.leap;
        b_next.rd    = a_reg.rd;
        b_next.base  = sum_reg + k4_reg + off;
        b_next.year  = a_reg.year;
        b_next.month = a_reg.month;
        b_next.day   = a_reg.day;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end else begin
            if (ce_a) begin
                va_reg <= in_valid;
            end
            if (ce_b) begin
                vb_reg <= va_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ce_a) begin
            a_reg   <= in_data;
            sum_reg <= sum_next;
            k4_reg  <= k4_next;
        end
        if (ce_b) begin
            b_reg <= b_next;
        end
    end

    assign out_valid = vb_reg;
    assign out_data  = b_reg;

endmodule

// ===== sv/jcc_month_split.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jcc_month_split
// Three stages: day of year, month index term, month by reciprocal multiply.
// ----------------------------------------------------------------------------
module jcc_month_split (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  jcc_pkg::jcc_base_t in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output jcc_pkg::jcc_cal_t  out_data
);

    logic               va_reg;
    logic               vb_reg;
    logic               vc_reg;
    logic               ce_a;
    logic               ce_b;
    logic               ce_c;
    jcc_pkg::jcc_base_t a_reg;
    logic [8:0]         prior_a_reg;
    logic [8:0]         prior_a_next;
    logic signed [26:0] diff;
    jcc_pkg::jcc_base_t b_reg;
    logic [8:0]         prior_b_reg;
    logic [1:0]         corr_reg;
    logic [1:0]         corr_next;
    logic [12:0]        x_reg;
    logic [12:0]        x_next;
    logic [8:0]         days;
    logic               past_feb;
    logic [26:0]        mprod;
    jcc_pkg::jcc_cal_t  c_reg;
    jcc_pkg::jcc_cal_t  c_next;

    assign ce_c     = !vc_reg || out_ready;
    assign ce_b     = !vb_reg || ce_c;
    assign ce_a     = !va_reg || ce_b;
    assign in_ready = ce_a;

    always_comb begin
        diff         = 27'(in_data.rd) - in_data.base;
        prior_a_next = diff[8:0];
    end

    always_comb begin
        past_feb  = a_reg.leap ? (prior_a_reg >= 9'd60) : (prior_a_reg >= 9'd59);
        corr_next = past_feb ? (a_reg.leap ? 2'd1 : 2'd2) : 2'd0;
        days      = prior_a_reg + 9'(corr_next);
        x_next    = 13'(days) * 13'(jcc_pkg::MONTH_MUL) + 13'(jcc_pkg::MONTH_BIAS);
    end

    always_comb begin
        mprod          = 27'(x_reg) * 27'(jcc_pkg::MONTH_RECIP);
        c_next.b       = b_reg;
        c_next.prior   = prior_b_reg;
        c_next.corr    = corr_reg;
        c_next.month_c = mprod[jcc_pkg::MONTH_SHIFT +: 4];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
        end else begin
            if (ce_a) begin
                va_reg <= in_valid;
            end
            if (ce_b) begin
                vb_reg <= va_reg;
            end
            if (ce_c) begin
                vc_reg <= vb_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ce_a) begin
            a_reg       <= in_data;
            prior_a_reg <= prior_a_next;
        end
        if (ce_b) begin
            b_reg       <= a_reg;
            prior_b_reg <= prior_a_reg;
            corr_reg    <= corr_next;
            x_reg       <= x_next;
        end
        if (ce_c) begin
            c_reg <= c_next;
        end
    end

    assign out_valid = vc_reg;
    assign out_data  = c_reg;

endmodule

// ===== sv/julian_calendar_converter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// julian_calendar_converter
// Converts proleptic Julian dates to fixed day counts and back.
// ----------------------------------------------------------------------------
// Takes one item per clock while the output does not stall and returns one
// result per item, in order. Stages: input, year estimate by reciprocal
// multiply, year number and leap, the year-base adders, day of year, month
// index term, month by reciprocal multiply, output register. A stall on the
// output holds each stage that has a waiting item; empty stages keep taking
// new items. epoch_offset is written through the cfg channel and resets to -1;
// write it only while no item is in flight (the block does not enforce this).
// ----------------------------------------------------------------------------
module julian_calendar_converter (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [10:0] cfg_data,   // epoch_offset
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,    // date_year[15:0], date_month[19:16],
                                    // date_day[24:20], day_count[49:25], zeros
    input  logic        s_tuser,    // func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,    // fixed_day[24:0], out_year[40:25],
                                    // out_month[44:41], out_day[49:45],
                                    // leap_year[50], zeros
    output logic        m_tuser     // year_error
);

    logic signed [10:0]  epoch_reg;
    logic                v1_reg;
    logic                ce_1;
    jcc_pkg::jcc_in_t    s1_reg;
    jcc_pkg::jcc_in_t    s1_next;
    logic signed [15:0]  in_year;
    logic [3:0]          in_month;
    logic [4:0]          in_day;
    logic signed [24:0]  in_rd;
    logic signed [28:0]  num;
    logic signed [11:0]  adj;
    logic                in_leap;

    logic                yd_ready;
    logic                yd_valid;
    jcc_pkg::jcc_yr_t    yd_data;
    logic                yb_ready;
    logic                yb_valid;
    jcc_pkg::jcc_base_t  yb_data;
    logic                ms_ready;
    logic                ms_valid;
    jcc_pkg::jcc_cal_t   ms_data;

    logic                vo_reg;
    logic                ce_o;
    logic [55:0]         tdata_reg;
    logic [55:0]         tdata_next;
    logic                tuser_reg;
    logic                tuser_next;
    logic signed [11:0]  day_c;
    logic signed [17:0]  year_sat;
    logic [24:0]         o_fixed;
    logic [15:0]         o_year;
    logic [3:0]          o_month;
    logic [4:0]          o_day;
    logic                o_leap;

    // configuration
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            epoch_reg <= -11'sd1;
        end else if (cfg_valid) begin
            epoch_reg <= $signed(cfg_data);
        end
    end

    // input stage
    assign ce_1     = !v1_reg || yd_ready;
    assign s_tready = ce_1;

    always_comb begin
        in_year  = $signed(s_tdata[15:0]);
        in_month = s_tdata[19:16];
        in_day   = s_tdata[24:20];
        in_rd    = $signed(s_tdata[49:25]);
        in_leap  = jcc_pkg::leap_of(18'(in_year));
        num      = ((29'(in_rd) - 29'(epoch_reg)) <<< 2) + jcc_pkg::YEAR_NUM_OFS;
        if (in_month > 4'd2) begin
            adj = in_leap ? -12'sd1 : -12'sd2;
        end else begin
            adj = 12'sd0;
        end
        s1_next.func     = jcc_pkg::jcc_func_t'(s_tuser);
        s1_next.err      = (in_year == 16'sd0);
        s1_next.leap     = in_leap;
        s1_next.rd       = in_rd;
        s1_next.num      = num[27:0];
        s1_next.k_date   = (in_year < 16'sd0) ? in_year : in_year - 16'sd1;
        s1_next.date_off = 12'(jcc_pkg::month_lead(in_month)) + $signed({7'd0, in_day})
                           - 12'sd1 + adj;
        s1_next.year     = in_year;
        s1_next.month    = in_month;
        s1_next.day      = in_day;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (ce_1) begin
            v1_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce_1) begin
            s1_reg <= s1_next;
        end
    end

    jcc_year_div u_year_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (v1_reg),
        .in_ready  (yd_ready),
        .in_data   (s1_reg),
        .out_valid (yd_valid),
        .out_ready (yb_ready),
        .out_data  (yd_data)
    );

    jcc_year_base u_year_base (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .epoch     (epoch_reg),
        .in_valid  (yd_valid),
        .in_ready  (yb_ready),
        .in_data   (yd_data),
        .out_valid (yb_valid),
        .out_ready (ms_ready),
        .out_data  (yb_data)
    );

    jcc_month_split u_month_split (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (yb_valid),
        .in_ready  (ms_ready),
        .in_data   (yb_data),
        .out_valid (ms_valid),
        .out_ready (ce_o),
        .out_data  (ms_data)
    );

    // output register
    assign ce_o = !vo_reg || m_tready;

    always_comb begin
        day_c = $signed({3'd0, ms_data.prior}) + 12'sd1
                - 12'(jcc_pkg::month_lead(ms_data.month_c))
                + ((ms_data.month_c > 4'd2) ? $signed({10'd0, ms_data.corr}) : 12'sd0);
        if (ms_data.b.year > jcc_pkg::YEAR_MAX) begin
            year_sat = jcc_pkg::YEAR_MAX;
        end else if (ms_data.b.year < jcc_pkg::YEAR_MIN) begin
            year_sat = jcc_pkg::YEAR_MIN;
        end else begin
            year_sat = ms_data.b.year;
        end
        if (ms_data.b.func == jcc_pkg::FUNC_TO_DATE) begin
            o_fixed = ms_data.b.rd;
            o_year  = year_sat[15:0];
            o_month = ms_data.month_c;
            o_day   = day_c[4:0];
            o_leap  = ms_data.b.leap;
        end else if (ms_data.b.err) begin
            o_fixed = '0;
            o_year  = '0;
            o_month = '0;
            o_day   = '0;
            o_leap  = 1'b0;
        end else begin
            o_fixed = ms_data.b.base[24:0];
            o_year  = year_sat[15:0];
            o_month = ms_data.b.month;
            o_day   = ms_data.b.day;
            o_leap  = ms_data.b.leap;
        end
        tdata_next = {5'd0, o_leap, o_day, o_month, o_year, o_fixed};
        tuser_next = (ms_data.b.func == jcc_pkg::FUNC_TO_FIXED) && ms_data.b.err;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vo_reg <= 1'b0;
        end else if (ce_o) begin
            vo_reg <= ms_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce_o) begin
            tdata_reg <= tdata_next;
            tuser_reg <= tuser_next;
        end
    end

    assign m_tvalid = vo_reg;
    assign m_tdata  = tdata_reg;
    assign m_tuser  = tuser_reg;

endmodule

// ===== tb/sv/julian_calendar_converter_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// julian_calendar_converter_tb
// Self-checking bench for the Julian calendar converter.
// ----------------------------------------------------------------------------
// Streams date-to-day-count and day-count-to-date requests into the block.
// Each accepted request is converted by a behavioral model of the Julian
// calendar at the current epoch offset, and each result is checked field by
// field in order. Runs six phases, each with its own epoch offset, including
// both ends of the register range; the first four add random stalls on both sides.
// Covers year zero, out-of-range month and day values, and day counts far
// enough from the epoch to saturate the year.
// ----------------------------------------------------------------------------
module julian_calendar_converter_tb;

    localparam int DRAIN_CYCLES = 12;
    localparam int ITEMS_PER_PHASE = 150;
    localparam int MAX_PRINTED = 50;

    typedef struct {
        jcc_pkg::jcc_func_t func;
        logic signed [15:0] year;
        logic [3:0]         month;
        logic [4:0]         day;
        logic signed [24:0] count;
    } conv_req_t;

    typedef struct {
        logic signed [24:0] fixed_day;
        logic signed [15:0] year;
        logic [3:0]         month;
        logic [4:0]         day;
        logic               leap;
        logic               err;
    } conv_res_t;

    logic        aclk;
    logic        aresetn = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [10:0] cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;
    logic        m_tuser;

    conv_req_t          conv_pend_q[$];
    conv_res_t          conv_expect_q[$];
    conv_req_t          shown_req;
    logic signed [10:0] epoch_now = -11'sd1;
    int                 send_idle_pct = 11;
    int                 recv_idle_pct = 55;
    int                 mismatches = 0;
    int                 epoch_writes = 0;
    int                 n_to_fixed = 0;
    int                 n_to_date = 0;
    int                 n_year_zero = 0;
    int                 results_seen = 0;

    julian_calendar_converter i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        #(2_000_000);
        $display("julian_calendar_converter_tb: done, errors");
        $finish;
    end

    function automatic longint floor_quot(input longint a, input longint d);
        longint q;
        q = a / d;
        if ((a % d) != 0 && a < 0) begin
            q = q - 1;
        end
        return q;
    endfunction

    function automatic logic julian_leap(input longint y);
        longint m;
        m = y - 4 * floor_quot(y, 4);
        return (m == ((y > 0) ? 0 : 3));
    endfunction

    function automatic longint julian_day_number(input longint y, input longint m,
                                                 input longint d, input longint ep);
        longint yy;
        longint r;
        yy = (y < 0) ? y + 1 : y;
        r = ep - 1 + jcc_pkg::DAYS_PER_YEAR * (yy - 1) + floor_quot(yy - 1, 4)
            + floor_quot(367 * m - 362, 12) + d;
        if (m > 2) begin
            r = r + (julian_leap(y) ? -1 : -2);
        end
        return r;
    endfunction

    function automatic conv_res_t julian_convert(input conv_req_t req,
                                                 input logic signed [10:0] epoch);
        conv_res_t res;
        longint    ep, yr, mon, dy, rd, approx, prior, corr;
        logic      lp;
        ep = longint'(epoch);
        res.fixed_day = '0;
        res.year = '0;
        res.month = '0;
        res.day = '0;
        res.leap = 1'b0;
        res.err = 1'b0;
        if (req.func == jcc_pkg::FUNC_TO_FIXED) begin
            yr = longint'(req.year);
            if (yr == 0) begin
                res.err = 1'b1;
            end else begin
                res.fixed_day = 25'(julian_day_number(yr, longint'(req.month),
                                                      longint'(req.day), ep));
                res.year = req.year;
                res.month = req.month;
                res.day = req.day;
                res.leap = julian_leap(yr);
            end
        end else begin
            rd = longint'(req.count);
            approx = floor_quot(4 * (rd - ep) + jcc_pkg::YEAR_BIAS, jcc_pkg::YEAR_DIV);
            yr = (approx <= 0) ? approx - 1 : approx;
            lp = julian_leap(yr);
            prior = rd - julian_day_number(yr, 1, 1, ep);
            corr = 0;
            if (rd >= julian_day_number(yr, 3, 1, ep)) begin
                corr = lp ? 1 : 2;
            end
            mon = floor_quot(jcc_pkg::MONTH_MUL * (prior + corr) + jcc_pkg::MONTH_BIAS,
                             jcc_pkg::MONTH_DIV);
            dy = rd - julian_day_number(yr, mon, 1, ep) + 1;
            if (yr > 32767) begin
                yr = 32767;
            end
            if (yr < -32768) begin
                yr = -32768;
            end
            res.fixed_day = req.count;
            res.year = 16'(yr);
            res.month = 4'(mon);
            res.day = 5'(dy);
            res.leap = lp;
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        mismatches++;
        if (mismatches <= MAX_PRINTED) begin
            $display("julian_calendar_converter_tb: result %0d %s: got %0d, expected %0d",
                     results_seen, what, got, want);
        end
    endtask

    always @(posedge aclk) begin : driver
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                conv_expect_q.push_back(julian_convert(shown_req, epoch_now));
                if (shown_req.func == jcc_pkg::FUNC_TO_FIXED) begin
                    n_to_fixed++;
                    if (shown_req.year == 0) begin
                        n_year_zero++;
                    end
                end else begin
                    n_to_date++;
                end
            end
            if (!s_tvalid || s_tready) begin
                if (conv_pend_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    shown_req = conv_pend_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= {6'b0, shown_req.count, shown_req.day, shown_req.month,
                                shown_req.year};
                    s_tuser <= shown_req.func;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin : monitor
        conv_res_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (conv_expect_q.size() == 0) begin
                    report_mismatch("arrived with no item pending", 0, 0);
                end else begin
                    want = conv_expect_q.pop_front();
                    if ($signed(m_tdata[24:0]) !== want.fixed_day) begin
                        report_mismatch("fixed_day", $signed(m_tdata[24:0]), want.fixed_day);
                    end
                    if ($signed(m_tdata[40:25]) !== want.year) begin
                        report_mismatch("out_year", $signed(m_tdata[40:25]), want.year);
                    end
                    if (m_tdata[44:41] !== want.month) begin
                        report_mismatch("out_month", m_tdata[44:41], want.month);
                    end
                    if (m_tdata[49:45] !== want.day) begin
                        report_mismatch("out_day", m_tdata[49:45], want.day);
                    end
                    if (m_tdata[50] !== want.leap) begin
                        report_mismatch("leap_year", m_tdata[50], want.leap);
                    end
                    if (m_tuser !== want.err) begin
                        report_mismatch("year_error", m_tuser, want.err);
                    end
                end
            end
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic wait_drained();
        while (conv_pend_q.size() != 0 || s_tvalid || conv_expect_q.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_epoch(input logic signed [10:0] value);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        epoch_now = value;
        epoch_writes++;
    endtask

    task automatic push_date(input logic signed [15:0] y, input logic [3:0] m,
                             input logic [4:0] d);
        conv_req_t r;
        r.func = jcc_pkg::FUNC_TO_FIXED;
        r.year = y;
        r.month = m;
        r.day = d;
        r.count = 25'($urandom);
        conv_pend_q.push_back(r);
    endtask

    task automatic push_count(input logic signed [24:0] c);
        conv_req_t r;
        r.func = jcc_pkg::FUNC_TO_DATE;
        r.year = 16'($urandom);
        r.month = 4'($urandom);
        r.day = 5'($urandom);
        r.count = c;
        conv_pend_q.push_back(r);
    endtask

    task automatic push_random();
        conv_req_t r;
        r.func = ($urandom_range(1) == 0) ? jcc_pkg::FUNC_TO_FIXED : jcc_pkg::FUNC_TO_DATE;
        r.year = 16'($urandom);
        r.month = 4'($urandom);
        r.day = 5'($urandom);
        r.count = 25'($urandom);
        if (r.func == jcc_pkg::FUNC_TO_FIXED) begin
            case ($urandom_range(9))
                0: ;
                1: r.year = '0;
                default: r.year = 16'(int'($urandom_range(6000)) - 3000);
            endcase
            if ($urandom_range(7) != 0) begin
                r.month = 4'($urandom_range(12, 1));
                r.day = 5'($urandom_range(31, 1));
            end
        end else begin
            case ($urandom_range(9))
                0: ;
                1: r.count = 25'(int'($urandom_range(4000)) + 11_966_000);
                2: r.count = 25'(-int'($urandom_range(4000)) - 11_966_000);
                default: r.count = 25'(int'($urandom_range(2_400_000)) - 1_200_000);
            endcase
        end
        conv_pend_q.push_back(r);
    endtask

    initial begin
        logic signed [10:0] next_epoch;
        int                 spin;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        push_date(16'sd1, 4'd1, 5'd1);
        push_date(-16'sd1, 4'd12, 5'd31);
        push_date(16'sd0, 4'd5, 5'd10);
        push_date(16'sd0, 4'd0, 5'd0);
        push_date(16'sd32767, 4'd12, 5'd31);
        push_date(-16'sd32768, 4'd1, 5'd1);
        push_date(16'sd4, 4'd3, 5'd1);
        push_date(-16'sd5, 4'd2, 5'd29);
        push_date(16'sd3, 4'd0, 5'd0);
        push_date(16'sd100, 4'd15, 5'd31);
        push_date(-16'sd32767, 4'd13, 5'd0);
        push_count(-25'sd16777216);
        push_count(25'sd16777215);
        push_count(25'sd0);
        push_count(-25'sd1);
        push_count(25'sd1);
        push_count(-25'sd367);
        push_count(25'sd59);
        push_count(25'sd60);
        push_count(25'sd1460);
        push_count(25'sd1461);
        push_count(25'sd11968000);
        push_count(-25'sd11968500);

        for (int ph = 0; ph < 6; ph++) begin
            if (ph > 0) begin
                wait_drained();
                case (ph)
                    1: next_epoch = -11'sd1024;
                    2: next_epoch = 11'sd1023;
                    3: next_epoch = 11'sd0;
                    default: next_epoch = 11'($urandom);
                endcase
                write_epoch(next_epoch);
            end
            if (ph < 2) begin
                send_idle_pct = 11;
                recv_idle_pct = 55;
            end else if (ph < 4) begin
                send_idle_pct = 55;
                recv_idle_pct = 11;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (ph == 1 && n == ITEMS_PER_PHASE / 2) begin
                    wait_drained();
                end
                push_random();
            end
        end

        while (conv_pend_q.size() != 0 || s_tvalid) begin
            @(posedge aclk);
        end
        spin = 0;
        while (conv_expect_q.size() != 0 && spin < 2000) begin
            @(posedge aclk);
            spin++;
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (conv_expect_q.size() != 0) begin
            report_mismatch("results never arrived", 0, conv_expect_q.size());
        end

        $display("covered %0d items: %0d to day count (%0d with year zero), %0d to date",
                 n_to_fixed + n_to_date, n_to_fixed, n_year_zero, n_to_date);
        $display("julian_calendar_converter_tb: %0d epoch settings, %0d results, %0d mismatches",
                 epoch_writes + 1, results_seen, mismatches);
        if (mismatches == 0) begin
            $display("julian_calendar_converter_tb: done, clean");
        end else begin
            $display("julian_calendar_converter_tb: done, errors");
        end
        $finish;
    end

endmodule
